>>> hw/rtl/hse_pkg.sv
// Shared types and constants for the heap sort engine.
// Used by hse_store, hse_sort and heap_sort_engine; depends on nothing.
`default_nettype none

package hse_pkg;

    localparam int DATA_W      = 32;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = 6;
    localparam int CNT_W       = 7;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [CNT_W-1:0]         t_cnt;

    // One access request to the heap store: a write and two reads
    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_data wdata;
        logic  re;
        t_addr raddr_a;
        t_addr raddr_b;
    } t_mem_req;

endpackage

`default_nettype wire

>>> hw/rtl/hse_store.sv
// Heap store: one write port and two registered read ports.
// Depends on hse_pkg for the request struct and data types.
`default_nettype none

module hse_store (
    input  logic              i_clk,
    input  hse_pkg::t_mem_req i_req,
    output hse_pkg::t_data    o_rd_a,
    output hse_pkg::t_data    o_rd_b
);

    hse_pkg::t_data r_mem [hse_pkg::STORE_DEPTH];
    hse_pkg::t_data r_rd_a;
    hse_pkg::t_data r_rd_b;

    // Write one entry; read two, holding the read data when idle
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_a <= r_mem[i_req.raddr_a];
            r_rd_b <= r_mem[i_req.raddr_b];
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

`default_nettype wire

>>> hw/rtl/hse_sort.sv
// Heap sort sequencer: heap build and extraction through one shared comparator.
// Depends on hse_pkg; drives the heap store through a t_mem_req struct.
`default_nettype none

module hse_sort (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  hse_pkg::t_cnt     i_size,
    input  hse_pkg::t_data    i_rd_a,
    input  hse_pkg::t_data    i_rd_b,
    output hse_pkg::t_mem_req o_req,
    output logic              o_done
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_BUILD   = 3'd1;
    localparam logic [2:0] S_LOAD    = 3'd2;
    localparam logic [2:0] S_SIFT_RD = 3'd3;
    localparam logic [2:0] S_CMP_L   = 3'd4;
    localparam logic [2:0] S_CMP_R   = 3'd5;
    localparam logic [2:0] S_EXTRACT = 3'd6;
    localparam logic [2:0] S_SWAP    = 3'd7;

    logic [2:0]     r_state, n_state;
    logic           r_done, n_done;
    logic           r_phase, n_phase;   // 0: heap build, 1: extraction
    hse_pkg::t_cnt  r_n, n_n;
    hse_pkg::t_cnt  r_k, n_k;
    hse_pkg::t_cnt  r_size, n_size;
    hse_pkg::t_addr r_node, n_node;
    hse_pkg::t_data r_val, n_val;
    hse_pkg::t_data r_big, n_big;
    logic           r_sel_l, n_sel_l;

    hse_pkg::t_cnt  km1;
    logic [7:0]     lc;
    logic [7:0]     rc;
    logic [7:0]     size_ext;
    hse_pkg::t_data cmp_a;
    hse_pkg::t_data cmp_b;
    logic           cmp_gt;
    hse_pkg::t_mem_req req;

    assign km1      = r_k - 1'b1;
    assign lc       = {1'b0, r_node, 1'b1};
    assign rc       = {1'b0, r_node, 1'b0} + 8'd2;
    assign size_ext = {1'b0, r_size};

    // Shared signed comparator: left child against the sifted value, then
    // right child against the larger of those two
    assign cmp_a  = (r_state == S_CMP_L) ? i_rd_a : i_rd_b;
    assign cmp_b  = (r_state == S_CMP_L) ? r_val : r_big;
    assign cmp_gt = cmp_a > cmp_b;

    // Sequence the build and extraction loops
    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_phase = r_phase;
        n_n     = r_n;
        n_k     = r_k;
        n_size  = r_size;
        n_node  = r_node;
        n_val   = r_val;
        n_big   = r_big;
        n_sel_l = r_sel_l;
        req     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_n     = i_size;
                    n_k     = {1'b0, i_size[hse_pkg::CNT_W-1:1]};
                    n_phase = 1'b0;
                    n_state = S_BUILD;
                end
            end
            S_BUILD: begin
                if (r_k == '0) begin
                    n_k     = r_n;
                    n_phase = 1'b1;
                    n_state = S_EXTRACT;
                end else begin
                    n_k         = km1;
                    n_node      = km1[hse_pkg::ADDR_W-1:0];
                    n_size      = r_n;
                    req.re      = 1'b1;
                    req.raddr_a = km1[hse_pkg::ADDR_W-1:0];
                    n_state     = S_LOAD;
                end
            end
            S_LOAD: begin
                n_val   = i_rd_a;
                n_state = S_SIFT_RD;
            end
            S_SIFT_RD: begin
                if (lc >= size_ext) begin
                    // Leaf reached: drop the held value into the hole
                    req.we    = 1'b1;
                    req.waddr = r_node;
                    req.wdata = r_val;
                    n_state   = r_phase ? S_EXTRACT : S_BUILD;
                end else begin
                    req.re      = 1'b1;
                    req.raddr_a = lc[hse_pkg::ADDR_W-1:0];
                    req.raddr_b = rc[hse_pkg::ADDR_W-1:0];
                    n_state     = S_CMP_L;
                end
            end
            S_CMP_L: begin
                n_sel_l = cmp_gt;
                n_big   = cmp_gt ? i_rd_a : r_val;
                n_state = S_CMP_R;
            end
            S_CMP_R: begin
                req.we    = 1'b1;
                req.waddr = r_node;
                if ((rc < size_ext) && cmp_gt) begin
                    req.wdata = i_rd_b;
                    n_node    = rc[hse_pkg::ADDR_W-1:0];
                    n_state   = S_SIFT_RD;
                end else if (r_sel_l) begin
                    req.wdata = r_big;
                    n_node    = lc[hse_pkg::ADDR_W-1:0];
                    n_state   = S_SIFT_RD;
                end else begin
                    req.wdata = r_val;
                    n_state   = r_phase ? S_EXTRACT : S_BUILD;
                end
            end
            S_EXTRACT: begin
                if (r_k <= hse_pkg::CNT_W'(1)) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    req.re      = 1'b1;
                    req.raddr_a = '0;
                    req.raddr_b = km1[hse_pkg::ADDR_W-1:0];
                    n_state     = S_SWAP;
                end
            end
            S_SWAP: begin
                // Move the root to the end; sift the old last value from the root
                req.we    = 1'b1;
                req.waddr = km1[hse_pkg::ADDR_W-1:0];
                req.wdata = i_rd_a;
                n_val     = i_rd_b;
                n_node    = '0;
                n_size    = km1;
                n_k       = km1;
                n_state   = S_SIFT_RD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;
        r_n     <= n_n;
        r_k     <= n_k;
        r_size  <= n_size;
        r_node  <= n_node;
        r_val   <= n_val;
        r_big   <= n_big;
        r_sel_l <= n_sel_l;
    end

    assign o_req  = req;
    assign o_done = r_done;

endmodule

`default_nettype wire

>>> hw/rtl/heap_sort_engine.sv
// Heap sort engine: loads a list, sorts it in place, emits it ascending.
// Load: one item per cycle. Sort: n/2 + n - 1 sifts in the shared comparator sequencer;
// each level a value moves down takes a read, a left compare and a right compare.
// Emit: each result is read via the registered store read port and held until taken.
// No item is taken from the closing item until the last result is taken.
// Reset (i_rst_n low, synchronous) clears count, overflow and control; store keeps data.
`default_nettype none

module heap_sort_engine #(
    parameter int MAX_ITEMS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] value_res
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // [0] overflow
);

    localparam logic [2:0] T_LOAD     = 3'd0;
    localparam logic [2:0] T_START    = 3'd1;
    localparam logic [2:0] T_SORT     = 3'd2;
    localparam logic [2:0] T_EMIT_RD  = 3'd3;
    localparam logic [2:0] T_EMIT_LD  = 3'd4;
    localparam logic [2:0] T_EMIT_OUT = 3'd5;

    logic [2:0]     r_state, n_state;
    hse_pkg::t_cnt  r_count, n_count;
    logic           r_ovf, n_ovf;
    hse_pkg::t_cnt  r_emit_k, n_emit_k;
    logic           r_tvalid, n_tvalid;
    hse_pkg::t_data r_tdata, n_tdata;
    logic           r_tlast, n_tlast;

    logic              in_acc;
    logic              has_room;
    hse_pkg::t_cnt     emit_k1;
    hse_pkg::t_mem_req top_req;
    hse_pkg::t_mem_req sort_req;
    hse_pkg::t_mem_req mem_req;
    hse_pkg::t_data    rd_a;
    hse_pkg::t_data    rd_b;
    logic              sort_done;

    assign s_axis_tready = (r_state == T_LOAD);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign has_room      = r_count < hse_pkg::CNT_W'(MAX_ITEMS);
    assign emit_k1       = r_emit_k + 1'b1;

    hse_sort u_sort (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == T_START),
        .i_size  (r_count),
        .i_rd_a  (rd_a),
        .i_rd_b  (rd_b),
        .o_req   (sort_req),
        .o_done  (sort_done)
    );

    // Give the store to the sorter while it runs
    assign mem_req = ((r_state == T_START) || (r_state == T_SORT)) ? sort_req : top_req;

    hse_store u_store (
        .i_clk  (i_clk),
        .i_req  (mem_req),
        .o_rd_a (rd_a),
        .o_rd_b (rd_b)
    );

    // Load, sort handoff and emit sequencing
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_emit_k = r_emit_k;
        n_tvalid = r_tvalid;
        n_tdata  = r_tdata;
        n_tlast  = r_tlast;
        top_req  = '0;
        unique case (r_state)
            T_LOAD: begin
                if (in_acc) begin
                    if (has_room) begin
                        top_req.we    = 1'b1;
                        top_req.waddr = r_count[hse_pkg::ADDR_W-1:0];
                        top_req.wdata = s_axis_tdata;
                        n_count       = r_count + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (s_axis_tlast) begin
                        n_state = T_START;
                    end
                end
            end
            T_START: begin
                n_state = T_SORT;
            end
            T_SORT: begin
                if (sort_done) begin
                    n_emit_k = '0;
                    n_state  = T_EMIT_RD;
                end
            end
            T_EMIT_RD: begin
                top_req.re      = 1'b1;
                top_req.raddr_a = r_emit_k[hse_pkg::ADDR_W-1:0];
                top_req.raddr_b = r_emit_k[hse_pkg::ADDR_W-1:0];
                n_state         = T_EMIT_LD;
            end
            T_EMIT_LD: begin
                n_tvalid = 1'b1;
                n_tdata  = rd_a;
                n_tlast  = (emit_k1 == r_count);
                n_state  = T_EMIT_OUT;
            end
            T_EMIT_OUT: begin
                if (m_axis_tready) begin
                    n_tvalid = 1'b0;
                    if (r_tlast) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = T_LOAD;
                    end else begin
                        n_emit_k = emit_k1;
                        n_state  = T_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = T_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= T_LOAD;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_tvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_tvalid <= n_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_emit_k <= n_emit_k;
        r_tdata  <= n_tdata;
        r_tlast  <= n_tlast;
    end

    assign m_axis_tvalid = r_tvalid;
    assign m_axis_tdata  = r_tdata;
    assign m_axis_tlast  = r_tlast;
    assign m_axis_tuser  = r_ovf;

endmodule

`default_nettype wire

>>> sim/heap_sort_engine_test.sv
// Self-checking testbench for heap_sort_engine: streams signed lists in,
// checks sorted bursts out. Depends on hse_pkg and heap_sort_engine.
`timescale 1ns / 100ps

// One sorted element as it should leave the block
typedef struct {
    hse_pkg::t_data value;
    logic           last;
    logic           ovf;
} t_sorted_elem;

// Tracks the list being loaded and the sorted elements still owed by the block
class sort_scoreboard;
    int             capacity;
    hse_pkg::t_data open_list[$];     // kept in ascending order as items arrive
    logic           open_dropped;
    t_sorted_elem   owed[$];
    int             mismatches;
    int             checked;
    int             lists_closed;
    int             overflow_lists;

    function new(int cap);
        capacity       = cap;
        open_dropped   = 1'b0;
        mismatches     = 0;
        checked        = 0;
        lists_closed   = 0;
        overflow_lists = 0;
    endfunction

    // Note an accepted input item; on the closing item, queue the sorted burst
    function void note_item(hse_pkg::t_data v, logic l);
        int pos;
        t_sorted_elem e;
        if (open_list.size() < capacity) begin
            pos = 0;
            while (pos < open_list.size() && open_list[pos] <= v)
                pos++;
            open_list.insert(pos, v);
        end else begin
            open_dropped = 1'b1;
        end
        if (l) begin
            foreach (open_list[k]) begin
                e.value = open_list[k];
                e.last  = (k == open_list.size() - 1);
                e.ovf   = open_dropped;
                owed.push_back(e);
            end
            lists_closed++;
            if (open_dropped)
                overflow_lists++;
            open_list.delete();
            open_dropped = 1'b0;
        end
    endfunction

    // Compare one accepted result with the oldest owed element
    function void check_result(hse_pkg::t_data v, logic l, logic ovf);
        t_sorted_elem e;
        checked++;
        if (owed.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected result value=%0d last=%0b ovf=%0b", v, l, ovf);
            return;
        end
        e = owed.pop_front();
        if (v !== e.value || l !== e.last || ovf !== e.ovf) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"ERROR: result %0d expected value=%0d last=%0b ovf=%0b,",
                          " got value=%0d last=%0b ovf=%0b"},
                         checked, e.value, e.last, e.ovf, v, l, ovf);
        end
    endfunction

    function int pending();
        return owed.size();
    endfunction
endclass

module heap_sort_engine_test;

    localparam int CAPACITY   = 64;
    localparam int RAND_ITEMS = 440;
    localparam int LIMIT      = 500000;
    localparam int DRAIN      = 100;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;     // [31:0] value
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;     // [31:0] value_res
    logic        m_axis_tlast;
    logic        m_axis_tuser;     // [0] overflow

    int src_idle_pct;
    int snk_stall_pct;
    int cycle_cnt = 0;
    int items_sent = 0;
    hse_pkg::t_data prev_value = '0;

    sort_scoreboard sb = new(CAPACITY);

    heap_sort_engine #(
        .MAX_ITEMS(CAPACITY)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // Give up on a hung run
    initial begin
        while (cycle_cnt < LIMIT)
            @(posedge i_clk);
        $display("ERROR: timeout after %0d cycles, %0d results still owed",
                 cycle_cnt, sb.pending());
        $display("heap_sort_engine: mismatch");
        $finish;
    end

    // Take results, stalling at random
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_result($signed(m_axis_tdata), m_axis_tlast, m_axis_tuser);
            m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Present one item and hold it until the block takes it
    task automatic send_item(input hse_pkg::t_data v, input logic l);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= l;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sb.note_item(v, l);
        items_sent++;
        prev_value = v;
    endtask

    // Mix of full-range values, small values that tie often, extremes and repeats
    function automatic hse_pkg::t_data pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return $urandom;
        else if (r < 65)
            return $signed($urandom_range(15)) - 8;
        else if (r < 75) begin
            case ($urandom_range(3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end else if (r < 85)
            return prev_value;
        return $urandom;
    endfunction

    // Send a list of n items with random content, closing on the last one
    task automatic send_list(input int n);
        for (int k = 0; k < n; k++)
            send_item(pick_value(), k == n - 1);
    endtask

    initial begin
        int list_idx;
        int len;
        int r;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        src_idle_pct  = 10;
        snk_stall_pct = 52;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single-element list
        send_item(32'sd5, 1'b1);
        // Two elements, largest before smallest
        send_item(32'h7fff_ffff, 1'b0);
        send_item(32'h8000_0000, 1'b1);
        // Extremes, alternating bit patterns, sign boundary and ties
        send_item(32'h0000_0000, 1'b0);
        send_item(32'hffff_ffff, 1'b0);
        send_item(32'h0000_0001, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h7fff_ffff, 1'b0);
        send_item(32'h5555_5555, 1'b0);
        send_item(32'haaaa_aaaa, 1'b0);
        send_item(32'h0000_0001, 1'b0);
        send_item(32'h8000_0001, 1'b0);
        send_item(32'h7fff_fffe, 1'b1);
        // Already ascending list, then all-equal list
        send_item(-32'sd3, 1'b0);
        send_item(32'sd0, 1'b0);
        send_item(32'sd3, 1'b1);
        send_item(32'sd9, 1'b0);
        send_item(32'sd9, 1'b0);
        send_item(32'sd9, 1'b1);

        // Random lists: mostly short, some near or at capacity, a few overflowing
        list_idx = 0;
        while (items_sent < RAND_ITEMS + 19) begin
            r = $urandom_range(99);
            if (list_idx == 0)
                len = CAPACITY;              // exactly full
            else if (list_idx == 1)
                len = CAPACITY + 1;          // closing item itself dropped
            else if (list_idx == 2)
                len = CAPACITY + 6;          // several dropped
            else if (r < 70)
                len = $urandom_range(10, 1);
            else if (r < 85)
                len = $urandom_range(40, 11);
            else if (r < 93)
                len = $urandom_range(CAPACITY, CAPACITY - 4);
            else
                len = $urandom_range(CAPACITY + 8, CAPACITY + 1);
            // Trim the final list so the item total stays near the target
            if (list_idx > 2 && len > RAND_ITEMS + 19 - items_sent)
                len = RAND_ITEMS + 19 - items_sent;

            // Step through the idle profiles as the random part progresses
            case ((items_sent - 19) * 3 / RAND_ITEMS)
                0: begin
                    src_idle_pct  = 10;
                    snk_stall_pct = 52;
                end
                1: begin
                    src_idle_pct  = 52;
                    snk_stall_pct = 10;
                end
                default: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
            endcase
            send_list(len);
            list_idx++;
        end
        s_axis_tvalid <= 1'b0;

        // Drain the owed results, then watch for strays
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("Sent %0d items in %0d lists (%0d overflowed); checked %0d sorted results.",
                 items_sent, sb.lists_closed, sb.overflow_lists, sb.checked);
        $display("Errors: %0d, results left owed: %0d", sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("heap_sort_engine: match");
        end else begin
            $display("heap_sort_engine: mismatch");
        end
        $finish;
    end

endmodule
